// ----- hdl/gasp_pkg.sv -----
// Shared types and constants for the golden-angle spiral point core.
// No dependencies; imported by every module of the block.
package gasp_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COUNT_W    = 11;
    localparam int IDX_W      = 10;
    localparam int RAD_W      = 16;
    localparam int HGT_W      = 16;
    localparam int POS_W      = 17;
    localparam int NQ_W       = 17;
    localparam int MAG_W      = 16;

    localparam logic [31:0] GOLD_PHASE = 32'h61C88647;
    localparam logic [31:0] Q_B9 = 32'd172272;
    localparam logic [31:0] Q_B7 = 32'd5026995;
    localparam logic [31:0] Q_B5 = 32'd85569306;
    localparam logic [31:0] Q_B3 = 32'd693598669;
    localparam logic [31:0] Q_A1 = 32'd1686629713;

    localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] REG_OUTER_RADIUS = 2'd1;
    localparam logic [1:0] REG_SPAWN_HEIGHT = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] dv;
        logic [HGT_W-1:0] height;
        logic             in_range;
        logic             single;
        logic [1:0]       quad;
        logic [15:0]      u;
        logic [MAG_W-1:0] smag;
        logic [MAG_W-1:0] cmag;
        logic             sneg;
        logic             cneg;
        logic [NQ_W-1:0]  n;
        logic [NQ_W-1:0]  r;
    } item_t;

endpackage

// ----- hdl/gasp_angle.sv -----
// Index decode, golden-angle phase and quarter-sine polynomial pipeline.
// Depends on gasp_pkg.
module gasp_angle (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [gasp_pkg::IDX_W-1:0]   idx,
    input  logic [gasp_pkg::COUNT_W-1:0] cfg_count,
    input  logic [gasp_pkg::HGT_W-1:0]   cfg_height,
    output logic                      out_valid,
    input  logic                      out_ready,
    output gasp_pkg::item_t           out_item
);
    import gasp_pkg::*;

    localparam int N = 8;

    logic [N-1:0] v_reg;
    logic [N:0]   adv;
    item_t        it_reg  [N];
    item_t        it_next [N];
    logic [16:0]  vv_reg  [N][2];
    logic [16:0]  vv_next [N][2];
    logic [16:0]  s_reg   [N][2];
    logic [16:0]  s_next  [N][2];
    logic [30:0]  t_reg   [N][2];
    logic [30:0]  t_next  [N][2];

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        logic [31:0]        phase;
        logic [33:0]        psq;
        logic [47:0]        pm;
        logic [31:0]        qs;
        logic [16:0]        q;
        logic [MAG_W-1:0]   mag [2];

        // stage 0: resolve count, phase
        if (cfg_count == '0)
            cnt = COUNT_W'(1);
        else if (cfg_count > COUNT_W'(MAX_POINTS))
            cnt = COUNT_W'(MAX_POINTS);
        else
            cnt = cfg_count;
        phase = 32'({22'd0, idx} * GOLD_PHASE);
        it_next[0]          = '0;
        it_next[0].idx      = idx;
        it_next[0].dv       = IDX_W'(cnt - COUNT_W'(1));
        it_next[0].height   = cfg_height;
        it_next[0].in_range = {1'b0, idx} < cnt;
        it_next[0].single   = cnt == COUNT_W'(1);
        it_next[0].quad     = phase[31:30];
        it_next[0].u        = phase[29:14];

        for (int k = 1; k < N; k++)
        begin
            it_next[k] = it_reg[k-1];
        end
        for (int l = 0; l < 2; l++)
        begin
            vv_next[0][l] = '0;
            s_next[0][l]  = '0;
            t_next[0][l]  = '0;
            for (int k = 2; k < N; k++)
            begin
                vv_next[k][l] = vv_reg[k-1][l];
                s_next[k][l]  = s_reg[k-1][l];
                t_next[k][l]  = t_reg[k-1][l];
            end
            // lane 0 evaluates S(u), lane 1 evaluates S(65536 - u)
            vv_next[1][l] = (l == 0) ? {1'b0, it_reg[0].u}
                                     : 17'h10000 - {1'b0, it_reg[0].u};
            psq           = 34'(vv_next[1][l]) * 34'(vv_next[1][l]);
            s_next[1][l]  = psq[32:16];
            t_next[1][l]  = '0;

            pm            = 48'(Q_B9) * 48'(s_reg[1][l]);
            t_next[2][l]  = 31'(Q_B7) - 31'(pm >> 16);
            pm            = 48'(t_reg[2][l]) * 48'(s_reg[2][l]);
            t_next[3][l]  = 31'(Q_B5) - 31'(pm >> 16);
            pm            = 48'(t_reg[3][l]) * 48'(s_reg[3][l]);
            t_next[4][l]  = 31'(Q_B3) - 31'(pm >> 16);
            pm            = 48'(t_reg[4][l]) * 48'(s_reg[4][l]);
            t_next[5][l]  = 31'(Q_A1) - 31'(pm >> 16);
            pm            = 48'(t_reg[5][l]) * 48'(vv_reg[5][l]);
            t_next[6][l]  = 31'(pm >> 16);

            qs     = {1'b0, t_reg[6][l]} + 32'h4000;
            q      = 17'(qs >> 15);
            mag[l] = (q > 17'd32768) ? 16'h8000 : q[15:0];
        end

        case (it_reg[6].quad)
            2'd0:
            begin
                it_next[7].smag = mag[0]; it_next[7].sneg = 1'b0;
                it_next[7].cmag = mag[1]; it_next[7].cneg = 1'b0;
            end
            2'd1:
            begin
                it_next[7].smag = mag[1]; it_next[7].sneg = 1'b0;
                it_next[7].cmag = mag[0]; it_next[7].cneg = 1'b1;
            end
            2'd2:
            begin
                it_next[7].smag = mag[0]; it_next[7].sneg = 1'b1;
                it_next[7].cmag = mag[1]; it_next[7].cneg = 1'b1;
            end
            default:
            begin
                it_next[7].smag = mag[1]; it_next[7].sneg = 1'b1;
                it_next[7].cmag = mag[0]; it_next[7].cneg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (adv[k])
            begin
                it_reg[k] <= it_next[k];
                for (int l = 0; l < 2; l++)
                begin
                    vv_reg[k][l] <= vv_next[k][l];
                    s_reg[k][l]  <= s_next[k][l];
                    t_reg[k][l]  <= t_next[k][l];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_item  = it_reg[N-1];

endmodule

// ----- hdl/gasp_div.sv -----
// Restoring divider pipeline, one quotient bit per stage: n = (idx*2^16 + d/2) / d.
// Depends on gasp_pkg.
module gasp_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gasp_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output gasp_pkg::item_t out_item
);
    import gasp_pkg::*;

    localparam int N = NQ_W;

    logic [N-1:0]      v_reg;
    logic [N:0]        adv;
    item_t             it_reg   [N];
    item_t             it_next  [N];
    logic [IDX_W-1:0]  rem_reg  [N];
    logic [IDX_W-1:0]  rem_next [N];
    logic [NQ_W-1:0]   num_reg  [N];
    logic [NQ_W-1:0]   num_next [N];

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        item_t            it;
        logic [IDX_W-1:0] rem;
        logic [NQ_W-1:0]  num;
        logic [IDX_W:0]   t;
        logic             qb;

        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                // quotient stays below 2^17 for in-range items, so the top
                // dividend bits already form the partial remainder
                it  = in_item;
                rem = {1'b0, in_item.idx[IDX_W-1:1]};
                num = {in_item.idx[0], 16'(in_item.dv[IDX_W-1:1])};
            end
            else
            begin
                it  = it_reg[(k == 0) ? 0 : k - 1];
                rem = rem_reg[(k == 0) ? 0 : k - 1];
                num = num_reg[(k == 0) ? 0 : k - 1];
            end
            t  = {rem, num[NQ_W-1]};
            qb = t >= {1'b0, it.dv};
            if (qb)
                t = t - {1'b0, it.dv};
            rem_next[k] = t[IDX_W-1:0];
            num_next[k] = {num[NQ_W-2:0], qb};
            it_next[k]  = it;
            it_next[k].n = num_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (adv[k])
            begin
                it_reg[k]  <= it_next[k];
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_item  = it_reg[N-1];

endmodule

// ----- hdl/gasp_sqrt.sv -----
// Digit-by-digit square root pipeline, one root bit per stage: r = floor(sqrt(n*2^16)).
// Depends on gasp_pkg.
module gasp_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gasp_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output gasp_pkg::item_t out_item
);
    import gasp_pkg::*;

    localparam int N   = NQ_W;
    localparam int X_W = 2 * NQ_W;
    localparam int R_W = NQ_W + 2;

    logic [N-1:0]     v_reg;
    logic [N:0]       adv;
    item_t            it_reg    [N];
    item_t            it_next   [N];
    logic [X_W-1:0]   xs_reg    [N];
    logic [X_W-1:0]   xs_next   [N];
    logic [R_W-1:0]   rem_reg   [N];
    logic [R_W-1:0]   rem_next  [N];
    logic [NQ_W-1:0]  root_reg  [N];
    logic [NQ_W-1:0]  root_next [N];

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        item_t           it;
        logic [X_W-1:0]  xs;
        logic [R_W-1:0]  rem;
        logic [NQ_W-1:0] root;
        logic [R_W+1:0]  r2;
        logic [R_W+1:0]  trial;

        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                it   = in_item;
                xs   = {1'b0, in_item.n, 16'd0};
                rem  = '0;
                root = '0;
            end
            else
            begin
                it   = it_reg[(k == 0) ? 0 : k - 1];
                xs   = xs_reg[(k == 0) ? 0 : k - 1];
                rem  = rem_reg[(k == 0) ? 0 : k - 1];
                root = root_reg[(k == 0) ? 0 : k - 1];
            end
            r2    = {rem, xs[X_W-1:X_W-2]};
            trial = {2'b00, root, 2'b01};
            if (r2 >= trial)
            begin
                r2           = r2 - trial;
                root_next[k] = {root[NQ_W-2:0], 1'b1};
            end
            else
                root_next[k] = {root[NQ_W-2:0], 1'b0};
            rem_next[k] = r2[R_W-1:0];
            xs_next[k]  = {xs[X_W-3:0], 2'b00};
            it_next[k]  = it;
            it_next[k].r = root_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (adv[k])
            begin
                it_reg[k]   <= it_next[k];
                xs_reg[k]   <= xs_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_item  = it_reg[N-1];

endmodule

// ----- hdl/gasp_scale.sv -----
// Radius scaling, rounding and sign: three stages ending in the output register.
// Depends on gasp_pkg.
module gasp_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gasp_pkg::item_t               in_item,
    input  logic [gasp_pkg::RAD_W-1:0]    cfg_radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [gasp_pkg::POS_W-1:0] pos_x,
    output logic signed [gasp_pkg::POS_W-1:0] pos_y,
    output logic signed [gasp_pkg::HGT_W-1:0] pos_z,
    output logic                          index_valid
);
    import gasp_pkg::*;

    localparam int N     = 3;
    localparam int RAD_P = NQ_W + RAD_W;
    localparam int PRD_W = RAD_P + MAG_W;

    logic [N-1:0]       v_reg;
    logic [N:0]         adv;
    item_t              it0_reg;
    item_t              it1_reg;
    logic [RAD_P-1:0]   rad_reg;
    logic [POS_W-1:0]   mx_reg;
    logic [POS_W-1:0]   my_reg;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   py_reg;
    logic [HGT_W-1:0]   pz_reg;
    logic               iv_reg;
    logic [RAD_P-1:0]   rad_next;
    logic [PRD_W-1:0]   prod_x;
    logic [PRD_W-1:0]   prod_y;
    logic [POS_W-1:0]   px_next;
    logic [POS_W-1:0]   py_next;
    logic               live;

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign rad_next = RAD_P'(in_item.r) * RAD_P'(cfg_radius);
    assign prod_x   = PRD_W'(rad_reg) * PRD_W'(it0_reg.cmag) + (PRD_W'(1) << 30);
    assign prod_y   = PRD_W'(rad_reg) * PRD_W'(it0_reg.smag) + (PRD_W'(1) << 30);

    // single-point spirals and out-of-range indexes give zero offsets
    assign live    = it1_reg.in_range && !it1_reg.single;
    assign px_next = !live ? '0 : (it1_reg.cneg ? -mx_reg : mx_reg);
    assign py_next = !live ? '0 : (it1_reg.sneg ? -my_reg : my_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            if (adv[1])
                v_reg[1] <= v_reg[0];
            if (adv[2])
                v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            it0_reg <= in_item;
            rad_reg <= rad_next;
        end
        if (adv[1])
        begin
            it1_reg <= it0_reg;
            mx_reg  <= prod_x[POS_W+30:31];
            my_reg  <= prod_y[POS_W+30:31];
        end
        if (adv[2])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= it1_reg.in_range ? it1_reg.height : '0;
            iv_reg <= it1_reg.in_range;
        end
    end

    assign in_ready    = adv[0];
    assign out_valid   = v_reg[N-1];
    assign pos_x       = px_reg;
    assign pos_y       = py_reg;
    assign pos_z       = pz_reg;
    assign index_valid = iv_reg;

endmodule

// ----- hdl/golden_angle_spiral_point_core.sv -----
// Golden-angle spiral point core: APB registers and the four pipeline sections.
// Stages from input beat to output beat: 8 angle, 17 divide, 17 square root,
// 3 scale. Throughput: one beat per cycle while out_ready is held high, since
// every section is fully pipelined and stalls only on back-pressure.
// Reset: rst_n clears all valid bits and sets point_count 1, radius 0, height 0.
// Depends on gasp_pkg, gasp_angle, gasp_div, gasp_sqrt, gasp_scale.
module golden_angle_spiral_point_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gasp_pkg::IDX_W-1:0]        point_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gasp_pkg::POS_W-1:0] pos_x,
    output logic signed [gasp_pkg::POS_W-1:0] pos_y,
    output logic signed [gasp_pkg::HGT_W-1:0] pos_z,
    output logic                              index_valid
);
    import gasp_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [HGT_W-1:0]   height_reg;
    logic               wr_en;

    logic  a_valid, a_ready, d_valid, d_ready, s_valid, s_ready;
    item_t a_item, d_item, s_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_W'(1);
            radius_reg <= '0;
            height_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_POINT_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                REG_OUTER_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_SPAWN_HEIGHT: height_reg <= pwdata[HGT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_POINT_COUNT:  prdata = 32'(count_reg);
            REG_OUTER_RADIUS: prdata = 32'(radius_reg);
            REG_SPAWN_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    gasp_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .idx        (point_index),
        .cfg_count  (count_reg),
        .cfg_height (height_reg),
        .out_valid  (a_valid),
        .out_ready  (a_ready),
        .out_item   (a_item)
    );

    gasp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_item   (a_item),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item)
    );

    gasp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_item   (d_item),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .out_item  (s_item)
    );

    gasp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (s_item),
        .cfg_radius  (radius_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .index_valid (index_valid)
    );

endmodule

// ----- hdl/gasp_checker.sv -----
// Port-level checks for the golden-angle spiral point core, bound to the top level.
// Depends on gasp_pkg and golden_angle_spiral_point_core.
module gasp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [gasp_pkg::POS_W-1:0] pos_x,
    input logic signed [gasp_pkg::POS_W-1:0] pos_y,
    input logic signed [gasp_pkg::HGT_W-1:0] pos_z,
    input logic                              index_valid
);
    import gasp_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(pos_z) && $stable(index_valid))
        else $error("output beat changed while stalled");

    // an empty output stage means the whole pipe can take a beat
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_zero_oob: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_valid |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
        else $error("out-of-range beat carries nonzero position");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_x != 17'sh10000 && pos_y != 17'sh10000)
        else $error("position magnitude out of range");

endmodule

bind golden_angle_spiral_point_core gasp_checker u_gasp_checker (.*);
